// File: rtl/core/rhcm_pkg.sv
// Shared types, constants and command codes of the rolling hash chunk marker.
package rhcm_pkg;

  localparam int WINDOW_DEFAULT        = 8;
  localparam int POSITION_BITS_DEFAULT = 16;

  localparam int CFG_W   = 16;
  localparam int CFG_IDX = 2;
  localparam int MOD_W   = 17;
  localparam int DVD_W   = 32;
  localparam int CNT_W   = 6;

  localparam logic [CFG_W-1:0] BASE_RESET       = 16'd257;
  localparam logic [CFG_W-1:0] MODULUS_RESET    = 16'd4096;
  localparam logic [CFG_W-1:0] TOP_WEIGHT_RESET = 16'd0;
  localparam logic [CFG_W-1:0] MIN_GAP_RESET    = 16'd0;

  // Number of dividend bits fed through the reducer for each reduction.
  localparam logic [CNT_W-1:0] STEPS_HASH = 6'd16;
  localparam logic [CNT_W-1:0] STEPS_SUB  = 6'd24;
  localparam logic [CNT_W-1:0] STEPS_MAC  = 6'd32;

  typedef enum logic [CFG_IDX-1:0] {
    REG_HASH_BASE,
    REG_HASH_MODULUS,
    REG_TOP_WEIGHT,
    REG_MIN_GAP
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD_HASH,
    OP_STEP,
    OP_SET_T,
    OP_SUB_START,
    OP_DIFF,
    OP_LOAD_MAC,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic fill;
    logic slot_free;
  } dp_status_t;

endpackage

// File: rtl/core/rhcm_datapath.sv
// Datapath: configuration, window history, shift-subtract modulo reducer and result register.
module rhcm_datapath import rhcm_pkg::*; #(
  parameter int WINDOW        = WINDOW_DEFAULT,
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CFG_IDX-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [7:0]         data_byte,
  input  logic               last_of_packet,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        marker_position,
  output logic [15:0]        marker_ordinal
);

  localparam int GW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  logic [CFG_W-1:0] hash_base;
  logic [CFG_W-1:0] hash_modulus;
  logic [CFG_W-1:0] top_weight;
  logic [CFG_W-1:0] min_gap;
  logic [MOD_W-1:0] modulus_eff;

  logic [15:0]              hreg;
  logic [7:0]               hist [WINDOW];
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] hit_pos;
  logic [15:0]              mcount;
  logic [7:0]               cur_byte;
  logic                     cur_last;
  logic [15:0]              areg;
  logic [15:0]              treg;

  logic [15:0]      rem;
  logic [DVD_W-1:0] dvd;
  logic [CNT_W-1:0] cnt;

  logic [MOD_W-1:0] shifted;
  logic [15:0]      rem_step;
  logic [17:0]      diff_sum;
  logic [17:0]      diff_red;
  logic [23:0]      sub_prod;
  logic [DVD_W-1:0] mac_val;
  logic             fill;
  logic             window_end;
  logic [GW-1:0]    gap_dist;
  logic             gap_ok;
  logic             hit;
  logic             slot_free;
  logic [31:0]      pos_wide;

  assign modulus_eff = (hash_modulus == '0) ? 17'h10000 : {1'b0, hash_modulus};

  // One restoring step: the partial remainder stays below the modulus.
  assign shifted  = {rem, dvd[DVD_W-1]};
  assign rem_step = (shifted >= modulus_eff) ? 16'(shifted - modulus_eff) : shifted[15:0];

  // Both operands are below the modulus, so one conditional subtract suffices.
  assign diff_sum = {2'b00, areg} + {1'b0, modulus_eff} - {2'b00, rem};
  assign diff_red = (diff_sum >= {1'b0, modulus_eff}) ? diff_sum - {1'b0, modulus_eff}
                                                      : diff_sum;

  assign sub_prod = 24'(hist[WINDOW-1]) * 24'(top_weight);
  assign mac_val  = 32'(treg) * 32'(hash_base) + 32'(cur_byte);

  assign fill       = (pos <= POSITION_BITS'(WINDOW - 1));
  assign window_end = (pos == POSITION_BITS'(WINDOW - 1));
  assign gap_dist   = GW'(pos - hit_pos);
  assign gap_ok     = (gap_dist >= GW'(min_gap));
  assign hit        = (rem == '0) && (window_end || (!fill && gap_ok));
  assign slot_free  = !out_valid || !out_stall;
  assign pos_wide   = 32'(pos);

  assign status.done      = (cnt == '0);
  assign status.fill      = fill;
  assign status.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_base    <= BASE_RESET;
      hash_modulus <= MODULUS_RESET;
      top_weight   <= TOP_WEIGHT_RESET;
      min_gap      <= MIN_GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_HASH_BASE:    hash_base    <= cfg_data;
        REG_HASH_MODULUS: hash_modulus <= cfg_data;
        REG_TOP_WEIGHT:   top_weight   <= cfg_data;
        REG_MIN_GAP:      min_gap      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Packet state, reducer count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      hreg      <= '0;
      pos       <= '0;
      hit_pos   <= '0;
      mcount    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < WINDOW; i++) hist[i] <= '0;
    end else begin
      if (cmd.op == OP_COMMIT && hit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD_HASH: cnt <= STEPS_HASH;
        OP_SUB_START: cnt <= STEPS_SUB;
        OP_LOAD_MAC:  cnt <= STEPS_MAC;
        OP_STEP:      cnt <= cnt - 1'b1;
        OP_COMMIT: begin
          if (hit && !cur_last) begin
            if (mcount != 16'hFFFF) mcount <= mcount + 1'b1;
            if (!window_end) hit_pos <= pos;
          end
          if (cur_last) begin
            hreg    <= '0;
            pos     <= '0;
            hit_pos <= '0;
            mcount  <= '0;
            for (int i = 0; i < WINDOW; i++) hist[i] <= '0;
          end else begin
            hreg <= rem;
            if (pos != '1) pos <= pos + 1'b1;
            hist[0] <= cur_byte;
            for (int i = 1; i < WINDOW; i++) hist[i] <= hist[i-1];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_HASH: begin
        cur_byte <= data_byte;
        cur_last <= last_of_packet;
        rem      <= '0;
        dvd      <= {hreg, 16'h0000};
      end
      OP_STEP: begin
        rem <= rem_step;
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
      OP_SET_T: treg <= rem;
      OP_SUB_START: begin
        areg <= rem;
        rem  <= '0;
        dvd  <= {sub_prod, 8'h00};
      end
      OP_DIFF: treg <= diff_red[15:0];
      OP_LOAD_MAC: begin
        rem <= '0;
        dvd <= mac_val;
      end
      OP_COMMIT: begin
        if (hit) begin
          marker_position <= pos_wide[15:0];
          marker_ordinal  <= mcount;
        end
      end
      default: ;
    endcase
  end

  a_step_below_modulus: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP) |=> ({1'b0, rem} < modulus_eff))
    else $error("reducer remainder not below modulus");

  a_diff_below_modulus: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIFF) |=> ({1'b0, treg} < modulus_eff))
    else $error("difference term not reduced");

  a_no_idle_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP) |-> !status.done)
    else $error("reducer stepped with no bits left");

endmodule

// File: rtl/core/rhcm_ctrl.sv
// Controller state machine sequencing the reductions for one byte.
module rhcm_ctrl import rhcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_HASH,
    S_RED_SUB,
    S_MAC_START,
    S_RED_MAC,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD_HASH;
          state_next = S_RED_HASH;
        end
      end
      S_RED_HASH: begin
        if (!status.done) begin
          cmd.op = OP_STEP;
        end else if (status.fill) begin
          // While the first window fills, the hash is built by Horner's rule.
          cmd.op     = OP_SET_T;
          state_next = S_MAC_START;
        end else begin
          cmd.op     = OP_SUB_START;
          state_next = S_RED_SUB;
        end
      end
      S_RED_SUB: begin
        if (!status.done) begin
          cmd.op = OP_STEP;
        end else begin
          cmd.op     = OP_DIFF;
          state_next = S_MAC_START;
        end
      end
      S_MAC_START: begin
        cmd.op     = OP_LOAD_MAC;
        state_next = S_RED_MAC;
      end
      S_RED_MAC: begin
        if (!status.done) begin
          cmd.op = OP_STEP;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (status.slot_free) begin
          cmd.op     = OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_commit_has_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COMMIT) |-> status.slot_free)
    else $error("commit would overwrite a pending marker");

  a_accept_starts_hash: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_RED_HASH))
    else $error("accepted beat did not start a reduction");

  a_reducer_idle_at_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> status.done)
    else $error("commit reached with reduction in progress");

endmodule

// File: rtl/core/rolling_hash_chunk_marker.sv
// Content-defined chunk marker: one byte beat at a time goes through a rolling
// hash over the last WINDOW bytes, reduced by a configured modulus in a shared
// shift-subtract reducer that handles one dividend bit per cycle. A byte takes a
// 16-bit and a 32-bit reduction while the first window fills, and 16-, 24- and
// 32-bit reductions plus setup steps once the window is full; the next byte is
// accepted in the cycle after its commit. A marker beat sits in an output
// register; while a stalled output holds it, the next byte waits before its
// commit cycle, so the stall lengthens that byte's processing.
// The user must write configuration through cfg_write, cfg_index and cfg_data
// only while idle; the block itself has no check for it.
module rolling_hash_chunk_marker import rhcm_pkg::*; #(
  parameter int WINDOW        = WINDOW_DEFAULT,
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CFG_IDX-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_of_packet,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        marker_position,
  output logic [15:0]        marker_ordinal
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rhcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rhcm_datapath #(
    .WINDOW        (WINDOW),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .data_byte       (data_byte),
    .last_of_packet  (last_of_packet),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .marker_position (marker_position),
    .marker_ordinal  (marker_ordinal)
  );

endmodule

// File: verif/rolling_hash_chunk_marker_checker.sv
// Checker for the chunk marker: tracks configuration, predicts markers and compares beats.
module rolling_hash_chunk_marker_checker import rhcm_pkg::*; #(
  parameter int WINDOW        = WINDOW_DEFAULT,
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CFG_IDX-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_of_packet,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        marker_position,
  input  logic [15:0]        marker_ordinal,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [15:0] position;
    logic [15:0] ordinal;
  } marker_t;

  localparam logic [63:0] POS_SAT = (64'd1 << POSITION_BITS) - 64'd1;

  logic [15:0] base_q;
  logic [15:0] modulus_q;
  logic [15:0] weight_q;
  logic [15:0] gap_q;

  logic [63:0] hash_q;
  logic [63:0] pos_q;
  logic [63:0] hit_pos_q;
  logic [63:0] ordinal_q;
  logic [7:0]  window_q [WINDOW];

  marker_t marker_q [$];

  function automatic void clear_packet_state();
    hash_q    = '0;
    pos_q     = '0;
    hit_pos_q = '0;
    ordinal_q = '0;
    foreach (window_q[i]) window_q[i] = '0;
  endfunction

  // Advances the rolling hash by one byte; returns 1 when the byte yields a marker.
  function automatic bit roll_byte(input logic [7:0] b, input logic last, output marker_t mk);
    logic [63:0] m;
    logic [63:0] h;
    logic [63:0] sub;
    logic [63:0] t;
    bit hit;
    m   = (modulus_q == '0) ? 64'd65536 : {48'd0, modulus_q};
    h   = hash_q % m;
    hit = 1'b0;
    mk  = '0;
    if (pos_q < WINDOW - 1) begin
      h = (h * base_q + b) % m;
    end else if (pos_q == WINDOW - 1) begin
      h   = (h * base_q + b) % m;
      hit = (h == 0);
    end else begin
      sub = ({56'd0, window_q[WINDOW-1]} * ({48'd0, weight_q} % m)) % m;
      t   = (h + m - sub) % m;
      t   = (t * base_q) % m;
      h   = (t + b) % m;
      // Later windows must also clear the distance from the last counted hit.
      if (h == 0 && (pos_q - hit_pos_q) >= gap_q) begin
        hit       = 1'b1;
        hit_pos_q = pos_q;
      end
    end
    hash_q = h;
    for (int i = WINDOW - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = b;
    if (hit) begin
      mk.position = pos_q[15:0];
      mk.ordinal  = ordinal_q[15:0];
      if (ordinal_q < 64'd65535) ordinal_q++;
    end
    if (pos_q < POS_SAT) pos_q++;
    if (last) clear_packet_state();
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    marker_t mk;
    marker_t exp_mk;
    if (rst) begin
      base_q     = BASE_RESET;
      modulus_q  = MODULUS_RESET;
      weight_q   = TOP_WEIGHT_RESET;
      gap_q      = MIN_GAP_RESET;
      fail_count = 0;
      clear_packet_state();
      marker_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_HASH_BASE:    base_q    = cfg_data;
          REG_HASH_MODULUS: modulus_q = cfg_data;
          REG_TOP_WEIGHT:   weight_q  = cfg_data;
          REG_MIN_GAP:      gap_q     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (roll_byte(data_byte, last_of_packet, mk)) marker_q.push_back(mk);
      end
      if (out_valid && !out_stall) begin
        if (marker_q.size() == 0) begin
          $error("unexpected marker beat: marker_position %0d marker_ordinal %0d",
                 marker_position, marker_ordinal);
          fail_count++;
        end else begin
          exp_mk = marker_q.pop_front();
          if (marker_position !== exp_mk.position) begin
            $error("marker_position: expected %0d, actual %0d", exp_mk.position,
                   marker_position);
            fail_count++;
          end
          if (marker_ordinal !== exp_mk.ordinal) begin
            $error("marker_ordinal: expected %0d, actual %0d", exp_mk.ordinal,
                   marker_ordinal);
            fail_count++;
          end
        end
      end
    end
    pending <= marker_q.size();
  end

endmodule

// File: verif/rolling_hash_chunk_marker_tb.sv
// Testbench top for the chunk marker: clock, reset, byte and configuration stimulus, verdict.
module rolling_hash_chunk_marker_tb import rhcm_pkg::*;;

  localparam int WINDOW         = WINDOW_DEFAULT;
  localparam int POSITION_BITS  = POSITION_BITS_DEFAULT;
  localparam int SETTLE_CYCLES  = 200;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 1050;

  logic               clk;
  logic               rst            = 1'b1;
  logic               cfg_write      = 1'b0;
  logic [CFG_IDX-1:0] cfg_index      = REG_HASH_BASE;
  logic [CFG_W-1:0]   cfg_data       = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte      = '0;
  logic               last_of_packet = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [15:0]        marker_position;
  logic [15:0]        marker_ordinal;

  int fail_count;
  int pending;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  rolling_hash_chunk_marker #(
    .WINDOW        (WINDOW),
    .POSITION_BITS (POSITION_BITS)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_of_packet  (last_of_packet),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .marker_position (marker_position),
    .marker_ordinal  (marker_ordinal)
  );

  rolling_hash_chunk_marker_checker #(
    .WINDOW        (WINDOW),
    .POSITION_BITS (POSITION_BITS)
  ) marker_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_of_packet  (last_of_packet),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .marker_position (marker_position),
    .marker_ordinal  (marker_ordinal),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls come in short runs, with an occasional long one that backs up a marker.
  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      stall_left <= ($urandom_range(0, 24) == 0) ? $urandom_range(80, 160)
                                                 : $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [15:0] window_weight(input logic [15:0] base,
                                                 input logic [15:0] modulus);
    logic [31:0] m;
    logic [31:0] r;
    m = (modulus == '0) ? 32'd65536 : {16'd0, modulus};
    r = 32'd1 % m;
    repeat (WINDOW - 1) r = (r * base) % m;
    return r[15:0];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 100)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    last_of_packet <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_markers_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Bytes without a marker may still be in flight once the queue empties, hence the settle.
  task automatic load_config(input logic [15:0] base, input logic [15:0] modulus,
                             input logic [15:0] weight, input logic [15:0] gap);
    wait_markers_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_HASH_BASE, base);
    write_reg(REG_HASH_MODULUS, modulus);
    write_reg(REG_TOP_WEIGHT, weight);
    write_reg(REG_MIN_GAP, gap);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_packet(input int len, input int fill);
    logic [7:0] fixed;
    logic [7:0] b;
    fixed = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (fill)
        0:       b = 8'($urandom_range(0, 255));
        1:       b = 8'd0;
        2:       b = fixed;
        default: b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    int r;
    int len;
    logic [15:0] base;
    logic [15:0] modulus;
    logic [15:0] weight;
    logic [15:0] gap;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a zero first window ending on the packet's last byte.
    for (int i = 0; i < WINDOW; i++) send_byte(8'h00, i == WINDOW - 1);
    // A packet shorter than the window.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // Zero modulus, top values elsewhere: only the first window may report.
    load_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < WINDOW + 2; i++) send_byte(8'h00, i == WINDOW + 1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      base = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      r = $urandom_range(0, 9);
      case (r)
        0:       modulus = 16'd1;
        1:       modulus = 16'd0;
        2:       modulus = 16'hFFFF;
        3:       modulus = 16'($urandom_range(25, 65535));
        default: modulus = 16'($urandom_range(2, 24));
      endcase
      if (phase == 2) modulus = 16'd1;
      r = $urandom_range(0, 9);
      case (r)
        0:       weight = 16'd0;
        1:       weight = 16'hFFFF;
        2:       weight = 16'($urandom_range(0, 65535));
        default: weight = window_weight(base, modulus);
      endcase
      r = $urandom_range(0, 9);
      gap = (r == 0) ? 16'hFFFF : (r < 4) ? 16'd0 : 16'($urandom_range(1, 20));
      calm = (phase == 4);
      load_config(base, modulus, weight, gap);

      // One long packet where every window hashes to zero.
      if (phase == 2) send_packet(300, $urandom_range(0, 3));

      phase_end = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 9);
        len = (r < 2) ? $urandom_range(1, WINDOW - 1)
            : (r < 9) ? $urandom_range(WINDOW, 40) : $urandom_range(41, 90);
        send_packet(len, $urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) wait_markers_done();
      end
      phase++;
    end
    calm = 1'b0;

    wait_markers_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
